FILE: src/lhf_pkg.sv
`default_nettype none
package lhf_pkg;
  typedef enum logic [1:0] {
    ACT_FRAME    = 2'd0,
    ACT_FADE_IN  = 2'd1,
    ACT_FADE_OUT = 2'd2,
    ACT_RESET    = 2'd3
  } action_e;

  localparam logic [2:0] REG_FRAMES = 3'd0;
  localparam logic [2:0] REG_BHUE   = 3'd1;
  localparam logic [2:0] REG_BVAL   = 3'd2;
  localparam logic [2:0] REG_STEP   = 3'd3;
  localparam logic [2:0] REG_SPREAD = 3'd4;
  localparam logic [2:0] REG_BOUNCE = 3'd5;
  localparam logic [2:0] REG_SMOOTH = 3'd6;

  localparam int DivW = 24;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic step_acc;
    logic step_fin;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic is_frame;
  } sts_t;
endpackage
`default_nettype wire

FILE: src/lhf_div.sv
`default_nettype none
module lhf_div import lhf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] num_i,
  input  wire logic [15:0]     den_i,
  output logic                 busy_o,
  output logic [DivW-1:0]      quo_o,
  output logic [15:0]          rem_o
);
  logic [4:0]      cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [16:0]     rem_q, rem_d;
  logic [15:0]     den_q, den_d;
  logic [16:0]     sh;

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    sh = {rem_q[15:0], quo_q[DivW-1]};
    if (start_i) begin
      cnt_d = 5'(DivW);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 5'd1;
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[15:0];
endmodule
`default_nettype wire

FILE: src/lhf_ctrl.sv
`default_nettype none
module lhf_ctrl import lhf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_DIV1  = 7'b0000100,
    S_WAIT1 = 7'b0001000,
    S_DIV2  = 7'b0010000,
    S_WAIT2 = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.is_frame) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV1: state_d = S_WAIT1;
      S_WAIT1: if (!sts_i.div_busy) begin
        cmd_o.step_acc = 1'b1;
        state_d = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = 1'b1;
        state_d = S_WAIT2;
      end
      S_WAIT2: if (!sts_i.div_busy && !cmd_o.div_start) begin
        cmd_o.step_fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_fin |=> out_valid_o) else $error("no result after finish");
endmodule
`default_nettype wire

FILE: src/lhf_dp.sv
`default_nettype none
module lhf_dp import lhf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic [49:0] in_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic [39:0]      out_data_o
);
  logic [15:0] fpl_q;
  logic [7:0]  bhue_q, bval_q, step_q, spread_q;
  logic        bounce_q, smooth_q;
  logic [7:0]  held_q, acc_q;
  logic [15:0] rem_q, fit_q, fil_q, fot_q, fol_q;
  logic [1:0]  act_q;
  logic [15:0] now_q, prev_q, el_q;
  logic [15:0] period_q;
  logic [7:0]  bri;

  logic            div_busy;
  logic [DivW-1:0] div_q, div_num;
  logic [15:0]     div_r, div_den;
  logic [15:0]     per_c, el_c;
  logic [32:0]     per3;
  logic [16:0]     rsum;
  logic [7:0]      acc_n, half, h3, hue_n;
  logic [15:0]     fil_n, fol_n;
  logic [23:0]     env_num;
  logic [15:0]     env_den;
  logic            env_zero;
  logic [7:0]      env_direct;

  // fpl / 3 via reciprocal, exact over the full 16-bit range
  assign per3 = 33'(fpl_q) * 33'd43691;
  always_comb begin
    if (bounce_q) per_c = per3[32:17];
    else per_c = {2'b00, fpl_q[15:2]};
    if (per_c == '0) per_c = 16'd1;
    if (now_q > prev_q) el_c = now_q - prev_q;
    else el_c = now_q + fpl_q - prev_q;
  end

  assign rsum = {1'b0, rem_q} + {1'b0, div_r};
  assign div_num = cmd_i.div_sel ? DivW'(rem_q) : DivW'(step_q * el_c);
  assign div_den = cmd_i.div_sel ? period_q : per_c;

  lhf_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_q), .rem_o(div_r)
  );

  assign acc_n = acc_q + div_q[7:0];
  assign hue_n = bhue_q + acc_n;
  assign fil_n = (el_q < fil_q) ? fil_q - el_q : '0;
  assign fol_n = (el_q < fol_q) ? fol_q - el_q : '0;

  always_comb begin
    env_zero = 1'b0;
    env_direct = bval_q;
    env_num = '0;
    env_den = 16'd1;
    if (fil_n != '0) begin
      env_num = 24'(fit_q - fil_n) * 24'd255;
      env_den = fit_q;
      env_zero = (fit_q == '0);
    end else if (fol_n != '0) begin
      env_num = 24'(fol_n) * 24'd255;
      env_den = fot_q;
      env_zero = (fot_q == '0);
    end else if (fot_q != '0) begin
      env_zero = 1'b1;
    end else begin
      env_den = '0;
    end
  end

  logic [15:0] env_d_q;
  logic        env_z_q, env_b_q;
  logic [4:0]  ecnt_q;
  logic [23:0] eq_q;
  logic [16:0] er_q, esh;

  assign esh = {er_q[15:0], eq_q[23]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_acc) begin
      env_d_q <= env_den;
      env_z_q <= env_zero;
      env_b_q <= (env_den == '0);
      eq_q <= env_num;
      er_q <= '0;
      ecnt_q <= 5'd24;
    end else if (ecnt_q != '0) begin
      ecnt_q <= ecnt_q - 5'd1;
      if (esh >= {1'b0, env_d_q}) begin
        er_q <= esh - {1'b0, env_d_q};
        eq_q <= {eq_q[22:0], 1'b1};
      end else begin
        er_q <= esh;
        eq_q <= {eq_q[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpl_q <= 16'd64; bhue_q <= '0; bval_q <= 8'd255; step_q <= '0;
      spread_q <= '0; bounce_q <= 1'b0; smooth_q <= 1'b0;
      held_q <= '0; acc_q <= '0; rem_q <= '0;
      fit_q <= '0; fil_q <= '0; fot_q <= '0; fol_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAMES: fpl_q <= cfg_data_i;
          REG_BHUE:   bhue_q <= cfg_data_i[7:0];
          REG_BVAL:   bval_q <= cfg_data_i[7:0];
          REG_STEP:   step_q <= cfg_data_i[7:0];
          REG_SPREAD: spread_q <= cfg_data_i[7:0];
          REG_BOUNCE: bounce_q <= cfg_data_i[0];
          REG_SMOOTH: smooth_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        case (action_e'(in_data_i[1:0]))
          ACT_FADE_IN:  begin fit_q <= in_data_i[49:34]; fil_q <= in_data_i[49:34]; end
          ACT_FADE_OUT: begin fot_q <= in_data_i[49:34]; fol_q <= in_data_i[49:34]; end
          ACT_RESET: begin fit_q <= '0; fil_q <= '0; fot_q <= '0; fol_q <= '0; end
          default: ;
        endcase
      end
      if (cmd_i.step_acc) begin
        acc_q <= acc_n;
        rem_q <= rsum[15:0];
        fil_q <= fil_n;
        fol_q <= fol_n;
      end
      if (cmd_i.step_fin) begin
        acc_q <= acc_n;
        rem_q <= div_r;
        if (smooth_q || (now_q[9:2] != prev_q[9:2])) held_q <= hue_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_data_i[1:0];
      now_q <= in_data_i[17:2];
      prev_q <= in_data_i[33:18];
    end
    if (cmd_i.div_start && !cmd_i.div_sel) begin
      el_q <= el_c;
      period_q <= per_c;
    end
  end

  assign bri = env_b_q ? env_direct : (env_z_q ? 8'd0 : eq_q[7:0]);
  assign half = {1'b0, spread_q[7:1]};
  assign h3 = 8'(3 * half);
  assign out_data_o = {bri, 8'(held_q - half), 8'(held_q + h3),
                       8'(held_q + half), 8'(held_q - h3)};
  assign sts_o.div_busy = div_busy;
  assign sts_o.is_frame = (action_e'(act_q) == ACT_FRAME);
endmodule
`default_nettype wire

FILE: src/led_hue_fade_frame_step_core.sv
// LED hue fade frame step.
// Input stream s_axis: one request per action (frame, fade in, fade out, reset fade);
// tuser carries the action, tdata the frame numbers and fade length.
// Output stream m_axis: one result per frame request, none for fade requests.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i writes register cfg_idx_i; the user must write
// only while idle, the block does not enforce it. A frame request runs two 24-step
// restoring divisions on a shared serial divider, the second of which also overlaps
// the 24-step brightness divider. One request is in flight at a time; the next is
// accepted after the result is taken or, for a fade request, once it is loaded. A
// stalled result holds m_axis_tdata and tvalid. Reset clears state and loads register
// defaults (loop 64, base value 255).
`default_nettype none
module led_hue_fade_frame_step_core import lhf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // frame_now[15:0], frame_prev[31:16], fade_length[47:32]
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // hue_top_left, hue_top_right, hue_bottom_left, hue_bottom_right, brightness
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  cmd_t cmd;
  sts_t sts;

  lhf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd)
  );

  lhf_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_data_i({s_axis_tdata, s_axis_tuser}),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .out_data_o(m_axis_tdata)
  );
endmodule
`default_nettype wire

FILE: tb/led_hue_fade_frame_step_core_tb.sv
`timescale 1ns / 1ps
module led_hue_fade_frame_step_core_tb;
  import lhf_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int NUM_PHASES = 8;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    action_e     act;
    logic [15:0] now;
    logic [15:0] prev;
    logic [15:0] len;
  } request_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  led_hue_fade_frame_step_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // register copy
  logic [15:0] loop_len;
  logic [7:0]  base_hue, base_val, hue_step, spread;
  logic        bounce, smooth;
  // block state copy
  logic [7:0]  hue_held, shift_acc;
  logic [15:0] shift_rem, in_total, in_left, out_total, out_left;

  request_t     pending_q[$];
  logic [39:0]  square_q[$];
  request_t     cur;
  int           send_idle_pct, recv_stall_pct;
  bit           hold_req, hold_done;
  int           hold_left;
  int           errors;
  int           frame_pos;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("led_hue_fade_frame_step_core_tb failed");
    $finish;
  end

  function automatic logic [15:0] drop_left(logic [15:0] left, logic [15:0] by);
    return (by < left) ? left - by : 16'd0;
  endfunction

  function automatic void add_req(request_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void predict_square(request_t r);
    int unsigned elapsed, period, prod, half, env;
    logic [7:0] tl, tr, bl, brr;
    case (r.act)
      ACT_FADE_IN: begin
        in_total = r.len;
        in_left = r.len;
      end
      ACT_FADE_OUT: begin
        out_total = r.len;
        out_left = r.len;
      end
      ACT_RESET: begin
        in_total = '0; in_left = '0; out_total = '0; out_left = '0;
      end
      default: begin
        if (r.now > r.prev) elapsed = r.now - r.prev;
        else elapsed = (r.now + loop_len - r.prev) & 32'hFFFF;
        period = loop_len / (4 - bounce);
        if (period == 0) period = 1;
        prod = hue_step * elapsed;
        shift_acc = shift_acc + 8'(prod / period);
        shift_rem = shift_rem + 16'(prod % period);
        shift_acc = shift_acc + 8'(shift_rem / period);
        shift_rem = 16'(shift_rem % period);
        if (smooth || r.now[9:2] != r.prev[9:2]) hue_held = base_hue + shift_acc;
        in_left = drop_left(in_left, 16'(elapsed));
        out_left = drop_left(out_left, 16'(elapsed));
        half = spread >> 1;
        tl = 8'(hue_held + 768 - 3 * half);
        tr = 8'(hue_held + half);
        bl = 8'(hue_held + 3 * half);
        brr = 8'(hue_held + 256 - half);
        if (in_left != 0)
          env = (in_total == 0) ? 0 : (255 * ((in_total - in_left) & 16'hFFFF)) / in_total;
        else if (out_left != 0)
          env = (out_total == 0) ? 0 : (255 * out_left) / out_total;
        else if (out_total != 0) env = 0;
        else env = base_val;
        square_q.insert(square_q.size(), {8'(env), brr, bl, tr, tl});
      end
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser <= '0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_square(cur);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur = pending_q.pop_front();
          s_axis_tuser <= cur.act;
          s_axis_tdata <= {cur.len, cur.prev, cur.now};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      hold_done = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [39:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (square_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = square_q.pop_front();
        for (int f = 0; f < 5; f++)
          if (want[f*8 +: 8] !== m_axis_tdata[f*8 +: 8]) begin
            $display("%0t: field %0d expected %h actual %h", $time, f,
                     want[f*8 +: 8], m_axis_tdata[f*8 +: 8]);
            errors++;
          end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_FRAMES: loop_len = val;
      REG_BHUE:   base_hue = val[7:0];
      REG_BVAL:   base_val = val[7:0];
      REG_STEP:   hue_step = val[7:0];
      REG_SPREAD: spread = val[7:0];
      REG_BOUNCE: bounce = val[0];
      REG_SMOOTH: smooth = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(int p);
    @(posedge clk_i);
    if (p == 1) begin
      write_reg(REG_FRAMES, 16'd4);
      write_reg(REG_BHUE, 16'd0);
      write_reg(REG_BVAL, 16'd0);
      write_reg(REG_STEP, 16'd0);
      write_reg(REG_SPREAD, 16'd0);
      write_reg(REG_BOUNCE, 16'd0);
      write_reg(REG_SMOOTH, 16'd0);
    end else if (p == 2) begin
      write_reg(REG_FRAMES, 16'hFFFF);
      write_reg(REG_BHUE, 16'hFFFF);
      write_reg(REG_BVAL, 16'hFFFF);
      write_reg(REG_STEP, 16'hFFFF);
      write_reg(REG_SPREAD, 16'hFFFF);
      write_reg(REG_BOUNCE, 16'hFFFF);
      write_reg(REG_SMOOTH, 16'hFFFF);
    end else begin
      write_reg(REG_FRAMES, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(4, 65535))
                                                         : 16'($urandom_range(4, 300)));
      write_reg(REG_BHUE, 16'($urandom));
      write_reg(REG_BVAL, 16'($urandom));
      write_reg(REG_STEP, 16'($urandom));
      write_reg(REG_SPREAD, 16'($urandom));
      write_reg(REG_BOUNCE, 16'($urandom));
      write_reg(REG_SMOOTH, 16'($urandom));
    end
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic request_t mk(action_e a, int n, int pv, int l);
    request_t r;
    r.act = a; r.now = 16'(n); r.prev = 16'(pv); r.len = 16'(l);
    return r;
  endfunction

  function automatic request_t random_request();
    int sel;
    int adv;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      adv = $urandom_range(0, 9);
      adv = (frame_pos + adv) % loop_len;
      random_request = mk(ACT_FRAME, adv, frame_pos, 0);
      frame_pos = adv;
    end else if (sel < 80) begin
      random_request = mk(($urandom_range(0, 1) != 0) ? ACT_FADE_IN : ACT_FADE_OUT, 0, 0,
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 40));
    end else if (sel < 83) begin
      random_request = mk(ACT_RESET, $urandom, $urandom, $urandom);
    end else begin
      random_request = mk(ACT_FRAME, $urandom, $urandom, $urandom);
    end
  endfunction

  initial begin
    errors = 0;
    hold_req = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    frame_pos = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    loop_len = 16'd64; base_hue = '0; base_val = 8'd255; hue_step = '0; spread = '0;
    bounce = 0; smooth = 0;
    hue_held = '0; shift_acc = '0; shift_rem = '0;
    in_total = '0; in_left = '0; out_total = '0; out_left = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) configure(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (p == 2) hold_req = 1;
      frame_pos = 0;
      if (p == 0) begin
        add_req(mk(ACT_FRAME, 0, 0, 0));
        add_req(mk(ACT_FRAME, 65535, 0, 0));
        add_req(mk(ACT_FRAME, 0, 65535, 65535));
        add_req(mk(ACT_FRAME, 65535, 65535, 0));
        add_req(mk(ACT_FRAME, 5, 1, 0));
        add_req(mk(ACT_FADE_IN, 0, 0, 20));
        add_req(mk(ACT_FRAME, 9, 5, 0));
        add_req(mk(ACT_FRAME, 30, 9, 0));
        add_req(mk(ACT_FADE_OUT, 0, 0, 16));
        add_req(mk(ACT_FRAME, 34, 30, 0));
        add_req(mk(ACT_FRAME, 63, 34, 0));
        add_req(mk(ACT_FADE_OUT, 0, 0, 0));
        add_req(mk(ACT_FRAME, 2, 63, 0));
        add_req(mk(ACT_RESET, 65535, 65535, 65535));
        add_req(mk(ACT_FADE_IN, 0, 0, 0));
        add_req(mk(ACT_FRAME, 3, 2, 0));
        add_req(mk(ACT_FADE_IN, 0, 0, 65535));
        add_req(mk(ACT_FRAME, 60, 3, 0));
        add_req(mk(ACT_FADE_OUT, 0, 0, 65535));
        add_req(mk(ACT_FRAME, 1, 60, 0));
        add_req(mk(ACT_RESET, 0, 0, 0));
        add_req(mk(ACT_FRAME, 4, 1, 0));
      end
      for (int i = 0; i < 235; i++) add_req(random_request());
      while (pending_q.size() > 0 || s_axis_tvalid || square_q.size() > 0)
        @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end
    if (errors == 0 && square_q.size() == 0) begin
      $display("led_hue_fade_frame_step_core_tb passed");
    end else begin
      $display("led_hue_fade_frame_step_core_tb failed");
    end
    $finish;
  end
endmodule
